// ===== rtl/core/fgat_pkg.sv =====
// Shared types and constants for the FEC group arrival tracker.
`timescale 1ns / 1ps
`default_nettype none

package fgat_pkg;

  // Width of packet indexes, counts and the divider datapath
  localparam int unsigned DataW = 11;

  // Width of the reported group id
  localparam int unsigned GidW = 10;

  // Width of the parity count register
  localparam int unsigned ParW = 10;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_ORIGINAL_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PARITY_COUNT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GROUP_COUNT    = 2'd2;

  // Input operation codes
  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Saturation limits of arrival counters and positions
  localparam logic [DataW-1:0] CNT_MAX = 11'd2047;
  localparam logic [DataW-1:0] POS_MAX = 11'd2047;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quot;
    logic [DataW-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/fgat_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module fgat_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fgat_pkg::div_req_t req_i,
  output fgat_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W    = fgat_pkg::DataW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quot_q, quot_d;
  logic [W-1:0]    divisor_q, divisor_d;
  logic [W:0]      trial;
  logic [W-1:0]    diff;
  logic            fits;

  // Shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial = {rem_q, quot_q[W-1]};
    diff  = trial[W-1:0] - divisor_q;
    fits  = trial >= {1'b0, divisor_q};
  end

  // Load on start, then iterate one bit per cycle
  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    divisor_d = divisor_q;
    if (req_i.start) begin
      busy_d    = 1'b1;
      cnt_d     = CntW'(W);
      rem_d     = '0;
      quot_d    = req_i.dividend;
      divisor_d = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = fits ? diff : trial[W-1:0];
      quot_d = {quot_q[W-2:0], fits};
      cnt_d  = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    quot_q    <= quot_d;
    divisor_q <= divisor_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/core/fec_group_arrival_tracker.sv =====
// Top level: per-group packet arrival tracking for an erasure-coded frame.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | input     | in_valid_i / in_stall_o  | op_i, packet_index_i
//  out     | output    | out_valid_o / out_stall_i| group_number_o, position_in_group_o,
//          |           |                        | group_now_complete_o, can_decode_o,
//          |           |                        | pending_groups_o, bad_index_o
//  cfg     | input     | cfg_we_i               | cfg_index_i, cfg_data_i
//
// An arrival runs two 11-bit dividers side by side (index mod/div groups, originals
// mod/div groups), then a counter memory read, a read-modify-write and a load of the
// output register. A bad index goes straight to the output register. A restart sweeps
// the counter memory one entry per cycle, then reports its result. After reset the
// same sweep runs over all MAX_GROUPS entries before the first item is taken.
// A stalled result waits in the output register; the block holds off the next item
// until its own result is loaded there.
`timescale 1ns / 1ps
`default_nettype none

module fec_group_arrival_tracker #(
  parameter int unsigned MAX_BUFFERS = 1024,
  parameter int unsigned MAX_GROUPS  = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [fgat_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fgat_pkg::DataW-1:0]        cfg_data_i,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [fgat_pkg::DataW-1:0]        packet_index_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fgat_pkg::GidW-1:0]         group_number_o,
  output logic [fgat_pkg::DataW-1:0]        position_in_group_o,
  output logic                              group_now_complete_o,
  output logic                              can_decode_o,
  output logic [fgat_pkg::DataW-1:0]        pending_groups_o,
  output logic                              bad_index_o
);

  localparam int unsigned W  = fgat_pkg::DataW;
  localparam int unsigned AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  // State codes
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state_q, state_d;

  // Configuration registers
  logic [W-1:0]                original_count_q;
  logic [fgat_pkg::ParW-1:0]   parity_count_q;
  logic [W-1:0]                group_count_q;

  // Per-item registers
  logic                      op_q, op_d;
  logic                      bad_q, bad_d;
  logic                      parity_q, parity_d;
  logic [AW-1:0]             gid_q, gid_d;
  logic [fgat_pkg::GidW-1:0] gid_out_q, gid_out_d;
  logic [W-1:0]              need_q, need_d;
  logic [W-1:0]              pos_q, pos_d;
  logic                      done_q, done_d;
  logic [W-1:0]              pending_q, pending_d;
  logic                      clr_reply_q, clr_reply_d;
  logic [AW-1:0]             clr_addr_q, clr_addr_d;

  // Output register
  logic                      out_valid_q, out_valid_d;
  logic [fgat_pkg::GidW-1:0] group_number_q, group_number_d;
  logic [W-1:0]              position_q, position_d;
  logic                      complete_q, complete_d;
  logic                      can_decode_q, can_decode_d;
  logic [W-1:0]              pending_out_q, pending_out_d;
  logic                      bad_out_q, bad_out_d;

  // Counter memory
  logic [W-1:0]  mem [MAX_GROUPS];
  logic [W-1:0]  rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [W-1:0]  mem_wdata;

  // Dividers
  fgat_pkg::div_req_t div_idx_req, div_k_req;
  fgat_pkg::div_rsp_t div_idx_rsp, div_k_rsp;

  logic         in_acc;
  logic         out_free;
  logic [W-1:0] k_eff;
  logic [W-1:0] g_eff;
  logic [W:0]   idx_limit;
  logic         idx_parity;
  logic [W-1:0] cnt_inc;
  logic [W:0]   pos_sum;
  logic [W-1:0] need_calc;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      original_count_q <= W'(1);
      parity_count_q   <= '0;
      group_count_q    <= W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        fgat_pkg::CFG_ORIGINAL_COUNT: original_count_q <= cfg_data_i;
        fgat_pkg::CFG_PARITY_COUNT:   parity_count_q   <= cfg_data_i[fgat_pkg::ParW-1:0];
        fgat_pkg::CFG_GROUP_COUNT:    group_count_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp originals and groups to their usable ranges
  always_comb begin
    if (original_count_q == '0) begin
      k_eff = W'(1);
    end else if (32'(original_count_q) > MAX_BUFFERS) begin
      k_eff = W'(MAX_BUFFERS);
    end else begin
      k_eff = original_count_q;
    end
    if (group_count_q == '0) begin
      g_eff = W'(1);
    end else begin
      g_eff = group_count_q;
    end
    if (g_eff > k_eff) begin
      g_eff = k_eff;
    end
    if (32'(g_eff) > MAX_GROUPS) begin
      g_eff = W'(MAX_GROUPS);
    end
  end

  // Range check and divider launch on accept
  always_comb begin
    idx_limit  = {1'b0, k_eff} + (W+1)'(parity_count_q);
    idx_parity = packet_index_i >= k_eff;

    div_idx_req.start    = in_acc && (op_i == fgat_pkg::OP_ARRIVAL) &&
                           ({1'b0, packet_index_i} < idx_limit);
    div_idx_req.dividend = idx_parity ? (packet_index_i - k_eff) : packet_index_i;
    div_idx_req.divisor  = g_eff;

    div_k_req.start    = div_idx_req.start;
    div_k_req.dividend = k_eff;
    div_k_req.divisor  = g_eff;
  end

  fgat_div u_div_idx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_idx_req),
    .rsp_o  (div_idx_rsp)
  );

  fgat_div u_div_k (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_k_req),
    .rsp_o  (div_k_rsp)
  );

  // Originals in the group: k div G, plus one for groups below k mod G
  always_comb begin
    need_calc = div_k_rsp.quot + W'(div_idx_rsp.rem < div_k_rsp.rem);
    pos_sum   = {1'b0, need_calc} + {1'b0, div_idx_rsp.quot};
    cnt_inc   = rdata_q + W'(1);
  end

  // Sequence one item
  always_comb begin
    state_d        = state_q;
    op_d           = op_q;
    bad_d          = bad_q;
    parity_d       = parity_q;
    gid_d          = gid_q;
    gid_out_d      = gid_out_q;
    need_d         = need_q;
    pos_d          = pos_q;
    done_d         = done_q;
    pending_d      = pending_q;
    clr_reply_d    = clr_reply_q;
    clr_addr_d     = clr_addr_q;
    out_valid_d    = out_valid_q && out_stall_i;
    group_number_d = group_number_q;
    position_d     = position_q;
    complete_d     = complete_q;
    can_decode_d   = can_decode_q;
    pending_out_d  = pending_out_q;
    bad_out_d      = bad_out_q;
    mem_we         = 1'b0;
    mem_waddr      = gid_q;
    mem_wdata      = cnt_inc;

    unique case (state_q)
      S_CLEAR: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(MAX_GROUPS - 1)) begin
          clr_addr_d = '0;
          state_d    = clr_reply_q ? S_RESULT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_d     = op_i;
          bad_d    = 1'b0;
          done_d   = 1'b0;
          parity_d = idx_parity;
          if (op_i == fgat_pkg::OP_RESTART) begin
            pending_d   = g_eff;
            clr_reply_d = 1'b1;
            state_d     = S_CLEAR;
          end else if (div_idx_req.start) begin
            state_d = S_DIV;
          end else begin
            bad_d   = 1'b1;
            state_d = S_RESULT;
          end
        end
      end
      S_DIV: begin
        if (div_idx_rsp.done && div_k_rsp.done) begin
          gid_d     = AW'(div_idx_rsp.rem);
          gid_out_d = div_idx_rsp.rem[fgat_pkg::GidW-1:0];
          need_d    = need_calc;
          if (!parity_q) begin
            pos_d = div_idx_rsp.quot;
          end else if (pos_sum[W]) begin
            pos_d = fgat_pkg::POS_MAX;
          end else begin
            pos_d = pos_sum[W-1:0];
          end
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        // Bump the saturating counter and retire the group on reaching its need
        if (rdata_q != fgat_pkg::CNT_MAX) begin
          mem_we = 1'b1;
          if (cnt_inc == need_q) begin
            done_d = 1'b1;
            if (pending_q != '0) begin
              pending_d = pending_q - W'(1);
            end
          end
        end
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          pending_out_d = pending_q;
          can_decode_d  = (pending_q == '0);
          bad_out_d     = bad_q;
          if ((op_q == fgat_pkg::OP_RESTART) || bad_q) begin
            group_number_d = '0;
            position_d     = '0;
            complete_d     = 1'b0;
          end else begin
            group_number_d = gid_out_q;
            position_d     = pos_q;
            complete_d     = done_q;
          end
          clr_reply_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      clr_reply_q <= 1'b0;
      pending_q   <= W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      clr_reply_q <= clr_reply_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q           <= op_d;
    bad_q          <= bad_d;
    parity_q       <= parity_d;
    gid_q          <= gid_d;
    gid_out_q      <= gid_out_d;
    need_q         <= need_d;
    pos_q          <= pos_d;
    done_q         <= done_d;
    group_number_q <= group_number_d;
    position_q     <= position_d;
    complete_q     <= complete_d;
    can_decode_q   <= can_decode_d;
    pending_out_q  <= pending_out_d;
    bad_out_q      <= bad_out_d;
  end

  // Counter memory: one write port, registered read at the current group
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[gid_q];
  end

  assign out_valid_o          = out_valid_q;
  assign group_number_o       = group_number_q;
  assign position_in_group_o  = position_q;
  assign group_now_complete_o = complete_q;
  assign can_decode_o         = can_decode_q;
  assign pending_groups_o     = pending_out_q;
  assign bad_index_o          = bad_out_q;

`ifndef SYNTHESIS
  // An accepted item keeps the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accept");

  // Decode flag agrees with the pending count
  a_decode_matches_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (can_decode_o == (pending_groups_o == '0)))
    else $error("can_decode disagrees with pending_groups");

  // A bad index reports no group and no completion
  a_bad_index_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_index_o |-> (group_number_o == '0) && !group_now_complete_o)
    else $error("bad index result carries group data");

  // Both dividers finish together
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_idx_rsp.done == div_k_rsp.done)
    else $error("dividers out of step");
`endif

endmodule

`default_nettype wire
